// File: design/jov_pkg.sv
// Package for the JSON object validator: parse phase codes, byte codes and
// literal spelling tables. No dependencies.
`timescale 1ns / 1ps

package jov_pkg;

    typedef logic [4:0] phase_t;

    localparam phase_t PH_LEAD      = 5'd0;
    localparam phase_t PH_OBJ_FIRST = 5'd1;
    localparam phase_t PH_OBJ_KEY   = 5'd2;
    localparam phase_t PH_COLON     = 5'd3;
    localparam phase_t PH_VALUE     = 5'd4;
    localparam phase_t PH_ARR_FIRST = 5'd5;
    localparam phase_t PH_AFTER     = 5'd6;
    localparam phase_t PH_TRAIL     = 5'd7;
    localparam phase_t PH_KSTR      = 5'd8;
    localparam phase_t PH_KESC      = 5'd9;
    localparam phase_t PH_KHEX      = 5'd10;
    localparam phase_t PH_VSTR      = 5'd11;
    localparam phase_t PH_VESC      = 5'd12;
    localparam phase_t PH_VHEX      = 5'd13;
    localparam phase_t PH_LIT       = 5'd14;
    localparam phase_t PH_MINUS     = 5'd15;
    localparam phase_t PH_ZERO      = 5'd16;
    localparam phase_t PH_INT       = 5'd17;
    localparam phase_t PH_DOT       = 5'd18;
    localparam phase_t PH_FRAC      = 5'd19;
    localparam phase_t PH_E         = 5'd20;
    localparam phase_t PH_ESIGN     = 5'd21;
    localparam phase_t PH_EXP       = 5'd22;

    typedef logic [1:0] lit_kind_t;

    localparam lit_kind_t LIT_TRUE  = 2'd0;
    localparam lit_kind_t LIT_FALSE = 2'd1;
    localparam lit_kind_t LIT_NULL  = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_CTRL_END = 8'h20;

    localparam logic [2:0] HEX_DIGITS = 3'd4;

    function automatic logic [2:0] lit_len(input lit_kind_t kind);
        case (kind)
            LIT_TRUE:  lit_len = 3'd4;
            LIT_FALSE: lit_len = 3'd5;
            LIT_NULL:  lit_len = 3'd4;
            default:   lit_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input lit_kind_t kind, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case ({kind, pos})
            {LIT_TRUE, 3'd0}:  c = CH_LO_T;
            {LIT_TRUE, 3'd1}:  c = CH_LO_R;
            {LIT_TRUE, 3'd2}:  c = CH_LO_U;
            {LIT_TRUE, 3'd3}:  c = CH_LO_E;
            {LIT_FALSE, 3'd0}: c = CH_LO_F;
            {LIT_FALSE, 3'd1}: c = CH_LO_A;
            {LIT_FALSE, 3'd2}: c = CH_LO_L;
            {LIT_FALSE, 3'd3}: c = CH_LO_S;
            {LIT_FALSE, 3'd4}: c = CH_LO_E;
            {LIT_NULL, 3'd0}:  c = CH_LO_N;
            {LIT_NULL, 3'd1}:  c = CH_LO_U;
            {LIT_NULL, 3'd2}:  c = CH_LO_L;
            {LIT_NULL, 3'd3}:  c = CH_LO_L;
            default:           c = 8'h00;
        endcase
        lit_char = c;
    endfunction

endpackage

// File: design/json_object_validator.sv
// JSON object validator top level: byte input register, grammar state machine,
// verdict output register. Depends on jov_pkg.
`timescale 1ns / 1ps
//
//  channel   | signals                                   | moves
//  ----------+-------------------------------------------+-----------------------------
//  input     | data_valid, data_stall, data_byte, last_byte | one document byte
//  result    | result_valid, result_stall, is_valid      | verdict for the finished doc
//  config    | cfg_write, cfg_data                       | depth_limit, no read-back
//
//  One byte per cycle sustained while data_stall is low; result_valid rises from a register
//  that is set when the state machine steps on the last byte held in the input register.
//  The grammar state machine advances once per byte from the input register.
//  Reset clears the parser state and sets depth_limit to 16.
//  A waiting verdict holds the input register only when the next byte is also a last byte;
//  otherwise bytes keep flowing while result_stall is high.

module json_object_validator
    import jov_pkg::*;
#(
    parameter int MAX_NESTING = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [4:0] cfg_data,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       is_valid
);

    localparam int LW = $clog2(MAX_NESTING + 1);
    localparam int CW = (LW + 1 > 5) ? LW + 1 : 5;

    logic [4:0]    depth_limit_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    phase_t        phase_reg, phase_next;
    logic          kinds_reg [0:MAX_NESTING];
    logic [LW-1:0] level_reg, level_next;
    logic [2:0]    hex_reg, hex_next;
    lit_kind_t     lit_kind_reg, lit_kind_next;
    logic [2:0]    lit_pos_reg, lit_pos_next;
    logic          error_reg, error_next;
    logic          out_valid_reg;
    logic          out_value_reg;

    logic          go;
    logic          step;
    logic [7:0]    b;
    logic          is_ws, is_digit, is_hex, is_esc, is_exp_mark;
    logic          cur_kind;
    logic [CW-1:0] eff_limit;
    logic [CW-1:0] up_level;
    logic          fail;
    logic          do_after, do_close, close_kind, do_start;
    logic          kind_we;
    logic [LW-1:0] kind_wa;
    logic          kind_wd;
    logic          verdict;

    assign go         = !(in_last_reg && out_valid_reg && result_stall);
    assign step       = in_valid_reg && go;
    assign data_stall = in_valid_reg && !go;

    assign b           = in_byte_reg;
    assign is_ws       = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_hex      = is_digit || ((b >= CH_LO_A) && (b <= CH_LO_F))
                         || ((b >= CH_UP_A) && (b <= CH_UP_F));
    assign is_esc      = (b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH)
                         || (b == CH_LO_B) || (b == CH_LO_F) || (b == CH_LO_N)
                         || (b == CH_LO_R) || (b == CH_LO_T);
    assign is_exp_mark = (b == CH_LO_E) || (b == CH_UP_E);
    assign cur_kind    = kinds_reg[level_reg];
    assign eff_limit   = (CW'(depth_limit_reg) > CW'(MAX_NESTING)) ? CW'(MAX_NESTING)
                                                                   : CW'(depth_limit_reg);
    assign up_level    = CW'(level_reg) + CW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        level_next    = level_reg;
        hex_next      = hex_reg;
        lit_kind_next = lit_kind_reg;
        lit_pos_next  = lit_pos_reg;
        fail          = 1'b0;
        do_after      = 1'b0;
        do_close      = 1'b0;
        close_kind    = 1'b0;
        do_start      = 1'b0;
        kind_we       = 1'b0;
        kind_wa       = level_reg;
        kind_wd       = 1'b0;

        unique case (phase_reg) inside
            PH_LEAD:
            begin
                if (b == CH_LBRACE)
                begin
                    level_next = '0;
                    kind_we    = 1'b1;
                    kind_wa    = '0;
                    kind_wd    = 1'b0;
                    phase_next = PH_OBJ_FIRST;
                end
                else if (!is_ws)
                    fail = 1'b1;
            end
            PH_OBJ_FIRST:
            begin
                if (b == CH_QUOTE)
                    phase_next = PH_KSTR;
                else if (b == CH_RBRACE)
                begin
                    do_close   = 1'b1;
                    close_kind = 1'b0;
                end
                else if (!is_ws)
                    fail = 1'b1;
            end
            PH_OBJ_KEY:
            begin
                if (b == CH_QUOTE)
                    phase_next = PH_KSTR;
                else if (!is_ws)
                    fail = 1'b1;
            end
            PH_COLON:
            begin
                if (b == CH_COLON)
                    phase_next = PH_VALUE;
                else if (!is_ws)
                    fail = 1'b1;
            end
            PH_VALUE:
                do_start = !is_ws;
            PH_ARR_FIRST:
            begin
                if (b == CH_RBRACK)
                begin
                    do_close   = 1'b1;
                    close_kind = 1'b1;
                end
                else
                    do_start = !is_ws;
            end
            PH_AFTER:
                do_after = 1'b1;
            PH_TRAIL:
                fail = !is_ws;
            PH_KSTR, PH_VSTR:
            begin
                if (b == CH_QUOTE)
                    phase_next = (phase_reg == PH_KSTR) ? PH_COLON : PH_AFTER;
                else if (b < CH_CTRL_END)
                    fail = 1'b1;
                else if (b == CH_BSLASH)
                    phase_next = phase_reg + 5'd1;
            end
            PH_KESC, PH_VESC:
            begin
                if (is_esc)
                    phase_next = phase_reg - 5'd1;
                else if (b == CH_LO_U)
                begin
                    hex_next   = HEX_DIGITS;
                    phase_next = phase_reg + 5'd1;
                end
                else
                    fail = 1'b1;
            end
            PH_KHEX, PH_VHEX:
            begin
                if (!is_hex || hex_reg == 3'd0)
                    fail = 1'b1;
                else
                begin
                    hex_next = hex_reg - 3'd1;
                    if (hex_reg == 3'd1)
                        phase_next = phase_reg - 5'd2;
                end
            end
            PH_LIT:
            begin
                if (lit_pos_reg >= lit_len(lit_kind_reg)
                    || b != lit_char(lit_kind_reg, lit_pos_reg))
                    fail = 1'b1;
                else
                begin
                    lit_pos_next = lit_pos_reg + 3'd1;
                    if (lit_pos_reg + 3'd1 == lit_len(lit_kind_reg))
                        phase_next = PH_AFTER;
                end
            end
            PH_MINUS:
            begin
                if (b == CH_ZERO)
                    phase_next = PH_ZERO;
                else if (is_digit)
                    phase_next = PH_INT;
                else
                    fail = 1'b1;
            end
            PH_ZERO, PH_INT:
            begin
                if (is_digit)
                    fail = (phase_reg == PH_ZERO);
                else if (b == CH_DOT)
                    phase_next = PH_DOT;
                else if (is_exp_mark)
                    phase_next = PH_E;
                else
                    do_after = 1'b1;
            end
            PH_DOT:
            begin
                if (is_digit)
                    phase_next = PH_FRAC;
                else
                    fail = 1'b1;
            end
            PH_FRAC:
            begin
                if (is_exp_mark)
                    phase_next = PH_E;
                else if (!is_digit)
                    do_after = 1'b1;
            end
            PH_E:
            begin
                if (b == CH_PLUS || b == CH_MINUS)
                    phase_next = PH_ESIGN;
                else if (is_digit)
                    phase_next = PH_EXP;
                else
                    fail = 1'b1;
            end
            PH_ESIGN:
            begin
                if (is_digit)
                    phase_next = PH_EXP;
                else
                    fail = 1'b1;
            end
            PH_EXP:
                do_after = !is_digit;
            default:
                fail = 1'b1;
        endcase

        if (do_after)
        begin
            phase_next = PH_AFTER;
            if (b == CH_COMMA)
                phase_next = cur_kind ? PH_VALUE : PH_OBJ_KEY;
            else if (b == CH_RBRACE)
            begin
                do_close   = 1'b1;
                close_kind = 1'b0;
            end
            else if (b == CH_RBRACK)
            begin
                do_close   = 1'b1;
                close_kind = 1'b1;
            end
            else if (!is_ws)
                fail = 1'b1;
        end

        if (do_close)
        begin
            if (cur_kind != close_kind)
                fail = 1'b1;
            else if (level_reg == '0)
                phase_next = PH_TRAIL;
            else
            begin
                level_next = level_reg - LW'(1);
                phase_next = PH_AFTER;
            end
        end

        if (do_start)
        begin
            if (up_level > eff_limit)
                fail = 1'b1;
            else if (b == CH_LBRACE || b == CH_LBRACK)
            begin
                level_next = LW'(up_level);
                kind_we    = 1'b1;
                kind_wa    = LW'(up_level);
                kind_wd    = (b == CH_LBRACK);
                phase_next = (b == CH_LBRACK) ? PH_ARR_FIRST : PH_OBJ_FIRST;
            end
            else if (b == CH_QUOTE)
                phase_next = PH_VSTR;
            else if (b == CH_LO_T || b == CH_LO_F || b == CH_LO_N)
            begin
                lit_kind_next = (b == CH_LO_T) ? LIT_TRUE
                              : (b == CH_LO_F) ? LIT_FALSE : LIT_NULL;
                lit_pos_next  = 3'd1;
                phase_next    = PH_LIT;
            end
            else if (b == CH_MINUS)
                phase_next = PH_MINUS;
            else if (b == CH_ZERO)
                phase_next = PH_ZERO;
            else if (b >= CH_ONE && b <= CH_NINE)
                phase_next = PH_INT;
            else
                fail = 1'b1;
        end

        // Drop everything once an error has stuck.
        if (error_reg)
        begin
            phase_next    = phase_reg;
            level_next    = level_reg;
            hex_next      = hex_reg;
            lit_kind_next = lit_kind_reg;
            lit_pos_next  = lit_pos_reg;
            fail          = 1'b0;
            kind_we       = 1'b0;
        end
        error_next = error_reg || fail;
    end

    assign verdict = !error_next && (phase_next == PH_TRAIL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= 5'd16;
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_LEAD;
            level_reg       <= '0;
            hex_reg         <= '0;
            lit_kind_reg    <= LIT_TRUE;
            lit_pos_reg     <= '0;
            error_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                depth_limit_reg <= cfg_data;

            if (data_valid && !data_stall)
                in_valid_reg <= 1'b1;
            else if (go)
                in_valid_reg <= 1'b0;

            if (step)
            begin
                if (in_last_reg)
                begin
                    phase_reg    <= PH_LEAD;
                    level_reg    <= '0;
                    hex_reg      <= '0;
                    lit_kind_reg <= LIT_TRUE;
                    lit_pos_reg  <= '0;
                    error_reg    <= 1'b0;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    level_reg    <= level_next;
                    hex_reg      <= hex_next;
                    lit_kind_reg <= lit_kind_next;
                    lit_pos_reg  <= lit_pos_next;
                    error_reg    <= error_next;
                end
            end

            if (step && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (step && kind_we)
            kinds_reg[kind_wa] <= kind_wd;
        if (step && in_last_reg)
            out_value_reg <= verdict;
    end

    assign result_valid = out_valid_reg;
    assign is_valid     = out_value_reg;

endmodule
